### sv/hta_pkg.sv
`default_nettype none
package hta_pkg;

  localparam int TEMP_W  = 8;
  localparam int CNT_W   = 16;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ENTER_TEMP    = 3'd0,
    REG_EXIT_TEMP     = 3'd1,
    REG_SAMPLE_PERIOD = 3'd2,
    REG_BLINK_PERIOD  = 3'd3,
    REG_BEEP_OFF_TIME = 3'd4,
    REG_BEEP_ON_TIME  = 3'd5
  } reg_idx_t;

  localparam logic signed [TEMP_W-1:0] ENTER_TEMP_RST    = 8'sd32;
  localparam logic signed [TEMP_W-1:0] EXIT_TEMP_RST     = 8'sd29;
  localparam logic [CNT_W-1:0]         SAMPLE_PERIOD_RST = 16'd500;
  localparam logic [CNT_W-1:0]         BLINK_PERIOD_RST  = 16'd500;
  localparam logic [CNT_W-1:0]         BEEP_OFF_TIME_RST = 16'd400;
  localparam logic [CNT_W-1:0]         BEEP_ON_TIME_RST  = 16'd100;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage
`default_nettype wire

### sv/hta_temp_if.sv
`default_nettype none
interface hta_temp_if;
  logic                                valid;
  logic                                ready;
  logic signed [hta_pkg::TEMP_W-1:0]   temperature_now;

  modport source (output valid, output temperature_now, input ready);
  modport sink   (input valid, input temperature_now, output ready);
endinterface
`default_nettype wire

### sv/hta_alarm_if.sv
`default_nettype none
interface hta_alarm_if;
  logic                                valid;
  logic                                ready;
  logic                                alarm_on;
  logic                                lamp_on;
  logic                                beeper_on;
  logic                                sample_taken;
  logic signed [hta_pkg::TEMP_W-1:0]   sampled_temp;

  modport source (output valid, output alarm_on, output lamp_on, output beeper_on,
                  output sample_taken, output sampled_temp, input ready);
  modport sink   (input valid, input alarm_on, input lamp_on, input beeper_on,
                  input sample_taken, input sampled_temp, output ready);
endinterface
`default_nettype wire

### sv/temperature_hysteresis_alarm_unit.sv
// Temperature alarm with hysteresis, LED blink and buzzer cadence.
// in_ch carries one beat per millisecond tick with the current reading in
// temperature_now. out_ch returns exactly one beat per input beat: alarm,
// LED and buzzer drive after that tick, a flag for a newly latched sample,
// and the last latched temperature.
// The beat waits in the input register, the evaluation runs combinationally
// on it, and the result register loads the result once that register is
// free or being drained. Throughput is one beat per cycle while the receiver
// keeps out_ch.ready high; the sustained rate is set by the single evaluation
// stage, which updates all timers and flags in one pass.
// When the receiver stalls, the result register holds its beat, the input
// register holds one more, and in_ch.ready drops only once both are full.
// Thresholds and periods are written over the APB port (byte address 4*i)
// and may be read back; write them only while no beat is in flight.
// Synchronous reset clears all timers and flags, empties both registers and
// restores the default thresholds and periods.
`default_nettype none
module temperature_hysteresis_alarm_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  hta_temp_if.sink                          in_ch,
  hta_alarm_if.source                       out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [hta_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [hta_pkg::DATA_W-1:0]   pwdata,
  output logic      [hta_pkg::DATA_W-1:0]   prdata,
  output logic                              pready
);

  // Configuration registers.
  logic signed [hta_pkg::TEMP_W-1:0] enter_temp;
  logic signed [hta_pkg::TEMP_W-1:0] exit_temp;
  logic [hta_pkg::CNT_W-1:0]         sample_period;
  logic [hta_pkg::CNT_W-1:0]         blink_period;
  logic [hta_pkg::CNT_W-1:0]         beep_off_time;
  logic [hta_pkg::CNT_W-1:0]         beep_on_time;

  logic [hta_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[hta_pkg::ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      enter_temp    <= hta_pkg::ENTER_TEMP_RST;
      exit_temp     <= hta_pkg::EXIT_TEMP_RST;
      sample_period <= hta_pkg::SAMPLE_PERIOD_RST;
      blink_period  <= hta_pkg::BLINK_PERIOD_RST;
      beep_off_time <= hta_pkg::BEEP_OFF_TIME_RST;
      beep_on_time  <= hta_pkg::BEEP_ON_TIME_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        hta_pkg::REG_ENTER_TEMP:    enter_temp    <= pwdata[hta_pkg::TEMP_W-1:0];
        hta_pkg::REG_EXIT_TEMP:     exit_temp     <= pwdata[hta_pkg::TEMP_W-1:0];
        hta_pkg::REG_SAMPLE_PERIOD: sample_period <= pwdata[hta_pkg::CNT_W-1:0];
        hta_pkg::REG_BLINK_PERIOD:  blink_period  <= pwdata[hta_pkg::CNT_W-1:0];
        hta_pkg::REG_BEEP_OFF_TIME: beep_off_time <= pwdata[hta_pkg::CNT_W-1:0];
        hta_pkg::REG_BEEP_ON_TIME:  beep_on_time  <= pwdata[hta_pkg::CNT_W-1:0];
        default: ;  // Addresses past the register list ignore writes.
      endcase
    end
  end

  // Readback returns the raw register bits, zero extended.
  always_comb begin
    case (reg_idx)
      hta_pkg::REG_ENTER_TEMP:
        prdata = {{(hta_pkg::DATA_W-hta_pkg::TEMP_W){1'b0}}, enter_temp};
      hta_pkg::REG_EXIT_TEMP:
        prdata = {{(hta_pkg::DATA_W-hta_pkg::TEMP_W){1'b0}}, exit_temp};
      hta_pkg::REG_SAMPLE_PERIOD:
        prdata = {{(hta_pkg::DATA_W-hta_pkg::CNT_W){1'b0}}, sample_period};
      hta_pkg::REG_BLINK_PERIOD:
        prdata = {{(hta_pkg::DATA_W-hta_pkg::CNT_W){1'b0}}, blink_period};
      hta_pkg::REG_BEEP_OFF_TIME:
        prdata = {{(hta_pkg::DATA_W-hta_pkg::CNT_W){1'b0}}, beep_off_time};
      hta_pkg::REG_BEEP_ON_TIME:
        prdata = {{(hta_pkg::DATA_W-hta_pkg::CNT_W){1'b0}}, beep_on_time};
      default:
        prdata = '0;
    endcase
  end

  // Input register. It refills in the same cycle that its beat moves on.
  logic                              in_valid_q;
  logic signed [hta_pkg::TEMP_W-1:0] temp_q;
  logic                              advance;
  logic                              out_valid;

  assign advance     = in_valid_q && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_valid_q || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      temp_q <= in_ch.temperature_now;
    end
  end

  // Tick state.
  logic [hta_pkg::CNT_W-1:0]         since_sample;
  logic [hta_pkg::CNT_W-1:0]         since_blink;
  logic [hta_pkg::CNT_W-1:0]         since_beep;
  logic                              alarm_flag;
  logic                              lamp_flag;
  logic                              beeper_flag;
  logic signed [hta_pkg::TEMP_W-1:0] held_temp;

  logic [hta_pkg::CNT_W-1:0]         since_sample_next;
  logic [hta_pkg::CNT_W-1:0]         since_blink_next;
  logic [hta_pkg::CNT_W-1:0]         since_beep_next;
  logic                              alarm_flag_next;
  logic                              lamp_flag_next;
  logic                              beeper_flag_next;
  logic signed [hta_pkg::TEMP_W-1:0] held_temp_next;
  logic                              take;

  // One tick: saturating counters first, then the sample and hysteresis,
  // then the blink and buzzer cadence using the counters as left by the
  // sample stage.
  always_comb begin
    since_sample_next = hta_pkg::sat_inc(since_sample);
    since_blink_next  = hta_pkg::sat_inc(since_blink);
    since_beep_next   = hta_pkg::sat_inc(since_beep);
    alarm_flag_next   = alarm_flag;
    lamp_flag_next    = lamp_flag;
    beeper_flag_next  = beeper_flag;
    held_temp_next    = held_temp;
    take              = (since_sample_next >= sample_period);

    if (take) begin
      since_sample_next = '0;
      held_temp_next    = temp_q;
      if (!alarm_flag) begin
        if (temp_q >= enter_temp) begin
          // Entering the alarm restarts both cadences from the off phase.
          alarm_flag_next  = 1'b1;
          lamp_flag_next   = 1'b0;
          beeper_flag_next = 1'b0;
          since_blink_next = '0;
          since_beep_next  = '0;
        end
      end else if (temp_q <= exit_temp) begin
        alarm_flag_next = 1'b0;
      end
    end

    if (alarm_flag_next) begin
      if (since_blink_next >= blink_period) begin
        since_blink_next = '0;
        lamp_flag_next   = !lamp_flag_next;
      end
      if (!beeper_flag_next && since_beep_next >= beep_off_time) begin
        since_beep_next  = '0;
        beeper_flag_next = 1'b1;
      end else if (beeper_flag_next && since_beep_next >= beep_on_time) begin
        since_beep_next  = '0;
        beeper_flag_next = 1'b0;
      end
    end else begin
      lamp_flag_next   = 1'b0;
      beeper_flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      since_sample <= '0;
      since_blink  <= '0;
      since_beep   <= '0;
      alarm_flag   <= 1'b0;
      lamp_flag    <= 1'b0;
      beeper_flag  <= 1'b0;
      held_temp    <= '0;
    end else if (advance) begin
      since_sample <= since_sample_next;
      since_blink  <= since_blink_next;
      since_beep   <= since_beep_next;
      alarm_flag   <= alarm_flag_next;
      lamp_flag    <= lamp_flag_next;
      beeper_flag  <= beeper_flag_next;
      held_temp    <= held_temp_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.alarm_on     <= alarm_flag_next;
      out_ch.lamp_on      <= lamp_flag_next;
      out_ch.beeper_on    <= beeper_flag_next;
      out_ch.sample_taken <= take;
      out_ch.sampled_temp <= held_temp_next;
    end
  end

  assign out_ch.valid = out_valid;

`ifndef ASSERT_OFF
  a_idle_outputs_off: assert property (@(posedge clk) disable iff (rst)
    !alarm_flag |-> !lamp_flag && !beeper_flag)
    else $error("lamp or beeper active while alarm is off");

  a_entry_restarts: assert property (@(posedge clk) disable iff (rst)
    $rose(alarm_flag) |-> since_blink == '0 && since_beep == '0)
    else $error("cadence timers not restarted on alarm entry");

  a_sample_clears: assert property (@(posedge clk) disable iff (rst)
    advance && take |=> since_sample == '0)
    else $error("sample timer not cleared after a sample");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    in_valid_q && !advance |=> in_valid_q && $stable(temp_q))
    else $error("pending input beat lost during output stall");
`endif

endmodule
`default_nettype wire

### tb/sv/tb_temperature_hysteresis_alarm_unit.sv
`timescale 1ns / 1ps
module tb_temperature_hysteresis_alarm_unit;

  // Run-length and pacing constants.
  localparam int RESET_CYCLES       = 9;
  localparam int CYCLE_LIMIT        = 2_000_000;
  localparam int DRAIN_LIMIT        = 20_000;
  // The unit is two registers deep, which bounds what can still be in flight.
  localparam int SETTLE_CYCLES      = 4;
  localparam int LONG_HOLD_CYCLES   = 300;
  localparam int PRESSURE_ITEMS     = 40;
  localparam int DEFAULT_RUN_TICKS  = 520;
  localparam int LONG_IDLE_TICKS    = 60;
  localparam int RANDOM_PHASES      = 10;
  localparam int RANDOM_PHASE_ITEMS = 65;

  // Byte addresses above the last register; writes there must change nothing.
  localparam logic [hta_pkg::ADDR_W-1:0] ADDR_UNMAPPED_LO = 5'd24;
  localparam logic [hta_pkg::ADDR_W-1:0] ADDR_UNMAPPED_HI = 5'd28;

  localparam logic [hta_pkg::CNT_W-1:0] PERIOD_MAX = 16'hFFFF;

  // One result beat as the alarm unit reports it after a tick.
  typedef struct packed {
    logic                              alarm;
    logic                              lamp;
    logic                              beeper;
    logic                              taken;
    logic signed [hta_pkg::TEMP_W-1:0] temp;
  } alarm_beat_t;

  logic clk;
  logic rst;

  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [hta_pkg::ADDR_W-1:0] paddr;
  logic [hta_pkg::DATA_W-1:0] pwdata;
  logic [hta_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  hta_temp_if  temp_ch ();
  hta_alarm_if alarm_ch ();

  temperature_hysteresis_alarm_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (temp_ch),
    .out_ch  (alarm_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mirror of the configuration registers, updated as each APB write lands.
  logic signed [hta_pkg::TEMP_W-1:0] cfg_enter_temp;
  logic signed [hta_pkg::TEMP_W-1:0] cfg_exit_temp;
  logic [hta_pkg::CNT_W-1:0]         cfg_sample_period;
  logic [hta_pkg::CNT_W-1:0]         cfg_blink_period;
  logic [hta_pkg::CNT_W-1:0]         cfg_beep_off_time;
  logic [hta_pkg::CNT_W-1:0]         cfg_beep_on_time;

  // Predicted internal state of the alarm: elapsed-time counters and flags.
  logic [hta_pkg::CNT_W-1:0]         elapsed_sample;
  logic [hta_pkg::CNT_W-1:0]         elapsed_blink;
  logic [hta_pkg::CNT_W-1:0]         elapsed_beep;
  logic                              alarm_state;
  logic                              lamp_state;
  logic                              beep_state;
  logic signed [hta_pkg::TEMP_W-1:0] latched_temp;

  // Beats that the unit still owes us, oldest first.
  alarm_beat_t expected_alarm_q[$];

  int  fail_count;
  int  cycle_count;
  bit  tx_gaps_on;
  bit  rx_stalls_on;
  bit  long_hold_req;
  int  stall_left;

  // The elapsed counters stick at their maximum instead of wrapping.
  function automatic logic [hta_pkg::CNT_W-1:0] count_up(input logic [hta_pkg::CNT_W-1:0] c);
    return (c == PERIOD_MAX) ? c : c + 1'b1;
  endfunction

  // Advance the predicted alarm by one millisecond tick and return the beat
  // the unit should report for it. The order matters: counters first, then
  // the sampling and hysteresis decision, then the lamp and beeper cadence.
  function automatic alarm_beat_t predict_alarm_tick(
      input logic signed [hta_pkg::TEMP_W-1:0] reading);
    alarm_beat_t beat;
    beat.taken = 1'b0;
    elapsed_sample = count_up(elapsed_sample);
    elapsed_blink  = count_up(elapsed_blink);
    elapsed_beep   = count_up(elapsed_beep);

    if (elapsed_sample >= cfg_sample_period) begin
      elapsed_sample = '0;
      latched_temp   = reading;
      beat.taken     = 1'b1;
      if (!alarm_state) begin
        // Entering the alarm restarts both cadences from the off phase.
        if (reading >= cfg_enter_temp) begin
          alarm_state   = 1'b1;
          lamp_state    = 1'b0;
          beep_state    = 1'b0;
          elapsed_blink = '0;
          elapsed_beep  = '0;
        end
      end else if (reading <= cfg_exit_temp) begin
        alarm_state = 1'b0;
      end
    end

    if (alarm_state) begin
      if (elapsed_blink >= cfg_blink_period) begin
        elapsed_blink = '0;
        lamp_state    = !lamp_state;
      end
      if (!beep_state && elapsed_beep >= cfg_beep_off_time) begin
        elapsed_beep = '0;
        beep_state   = 1'b1;
      end else if (beep_state && elapsed_beep >= cfg_beep_on_time) begin
        elapsed_beep = '0;
        beep_state   = 1'b0;
      end
    end else begin
      lamp_state = 1'b0;
      beep_state = 1'b0;
    end

    beat.alarm  = alarm_state;
    beat.lamp   = lamp_state;
    beat.beeper = beep_state;
    beat.temp   = latched_temp;
    return beat;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [hta_pkg::TEMP_W-1:0] near_temp(input int center,
                                                                  input int spread);
    int v;
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return v[hta_pkg::TEMP_W-1:0];
  endfunction

  // Any reading over the whole signed range.
  function automatic logic signed [hta_pkg::TEMP_W-1:0] any_temp();
    int r;
    r = $urandom_range(0, 255);
    return r[hta_pkg::TEMP_W-1:0];
  endfunction

  // Readings cluster around the two thresholds so that the hysteresis
  // actually switches; the rest span the whole signed range.
  function automatic logic signed [hta_pkg::TEMP_W-1:0] pick_reading();
    case ($urandom_range(0, 4))
      0, 1: return near_temp(cfg_enter_temp, 3);
      2, 3: return near_temp(cfg_exit_temp, 3);
      default: return any_temp();
    endcase
  endfunction

  // Periods are mostly short so that samples, blinks and beeps happen often
  // within a phase; zero and the full 16-bit value show up occasionally.
  function automatic logic [hta_pkg::CNT_W-1:0] pick_period();
    int r;
    int p;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return PERIOD_MAX;
    if (r < 5) p = $urandom_range(16, 200);
    else p = $urandom_range(1, 8);
    return p[hta_pkg::CNT_W-1:0];
  endfunction

  function automatic logic [hta_pkg::ADDR_W-1:0] reg_addr(input hta_pkg::reg_idx_t r);
    return {r, 2'b00};
  endfunction

  // One APB write: setup cycle, then the access cycle, which completes at the
  // edge where pready is seen high. The local mirror is updated right there,
  // and the bus is back to idle before the task returns.
  task automatic write_apb(input logic [hta_pkg::ADDR_W-1:0] addr,
                           input logic [hta_pkg::DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (hta_pkg::reg_idx_t'(addr[hta_pkg::ADDR_W-1:2]))
      hta_pkg::REG_ENTER_TEMP:    cfg_enter_temp    = data[hta_pkg::TEMP_W-1:0];
      hta_pkg::REG_EXIT_TEMP:     cfg_exit_temp     = data[hta_pkg::TEMP_W-1:0];
      hta_pkg::REG_SAMPLE_PERIOD: cfg_sample_period = data[hta_pkg::CNT_W-1:0];
      hta_pkg::REG_BLINK_PERIOD:  cfg_blink_period  = data[hta_pkg::CNT_W-1:0];
      hta_pkg::REG_BEEP_OFF_TIME: cfg_beep_off_time = data[hta_pkg::CNT_W-1:0];
      hta_pkg::REG_BEEP_ON_TIME:  cfg_beep_on_time  = data[hta_pkg::CNT_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_settings(input logic signed [hta_pkg::TEMP_W-1:0] enter_t,
                                input logic signed [hta_pkg::TEMP_W-1:0] exit_t,
                                input logic [hta_pkg::CNT_W-1:0] sample_p,
                                input logic [hta_pkg::CNT_W-1:0] blink_p,
                                input logic [hta_pkg::CNT_W-1:0] off_t,
                                input logic [hta_pkg::CNT_W-1:0] on_t);
    write_apb(reg_addr(hta_pkg::REG_ENTER_TEMP),
              {{(hta_pkg::DATA_W-hta_pkg::TEMP_W){1'b0}}, enter_t});
    write_apb(reg_addr(hta_pkg::REG_EXIT_TEMP),
              {{(hta_pkg::DATA_W-hta_pkg::TEMP_W){1'b0}}, exit_t});
    write_apb(reg_addr(hta_pkg::REG_SAMPLE_PERIOD),
              {{(hta_pkg::DATA_W-hta_pkg::CNT_W){1'b0}}, sample_p});
    write_apb(reg_addr(hta_pkg::REG_BLINK_PERIOD),
              {{(hta_pkg::DATA_W-hta_pkg::CNT_W){1'b0}}, blink_p});
    write_apb(reg_addr(hta_pkg::REG_BEEP_OFF_TIME),
              {{(hta_pkg::DATA_W-hta_pkg::CNT_W){1'b0}}, off_t});
    write_apb(reg_addr(hta_pkg::REG_BEEP_ON_TIME),
              {{(hta_pkg::DATA_W-hta_pkg::CNT_W){1'b0}}, on_t});
  endtask

  // Offers one tick beat and returns at the edge where it is accepted. Valid
  // stays high on return, so back-to-back beats never drop it in between.
  task automatic send_reading(input logic signed [hta_pkg::TEMP_W-1:0] reading);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      temp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    temp_ch.valid           <= 1'b1;
    temp_ch.temperature_now <= reading;
    do @(posedge clk); while (!temp_ch.ready);
  endtask

  // Stops offering beats and waits until every owed result has come back,
  // then lets the pipeline settle so a register write finds the unit idle.
  // The first edge lets the checker record the beat accepted last.
  task automatic wait_idle();
    int waited;
    waited = 0;
    temp_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_alarm_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_alarm_q.size() != 0) begin
      $error("%0d result beats never arrived", expected_alarm_q.size());
      fail_count++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reset values straight out of reset: one sample every 500 ms. The readings
  // stay at or above the default enter threshold, so the first sample raises
  // the alarm and the ticks after it start the default cadence from the off
  // phase.
  task automatic test_default_settings();
    for (int i = 0; i < DEFAULT_RUN_TICKS; i++) begin
      send_reading(near_temp(46, 14));
    end
    wait_idle();
  endtask

  // Thresholds at the ends of the signed range, with sample, blink and beep-off periods at one
  // and a longer beep-on time, so each tick samples and the lamp toggles as fast as it can.
  task automatic test_threshold_extremes();
    write_settings(8'sd127, -8'sd128, 16'd1, 16'd1, 16'd1, 16'd2);
    send_reading(-8'sd128);
    send_reading(8'sd126);
    send_reading(8'sd127);
    send_reading(8'sd0);
    send_reading(-8'sd127);
    send_reading(-8'sd128);
    send_reading(8'sd127);
    wait_idle();
    write_settings(-8'sd128, -8'sd128, 16'd1, 16'd1, 16'd1, 16'd2);
    send_reading(-8'sd128);
    send_reading(-8'sd128);
    send_reading(8'sd5);
    wait_idle();
  endtask

  // A period or time of zero makes its comparison true on every tick.
  task automatic test_zero_periods();
    write_settings(8'sd10, 8'sd5, '0, '0, '0, '0);
    send_reading(8'sd10);
    send_reading(8'sd7);
    send_reading(8'sd7);
    send_reading(8'sd7);
    send_reading(8'sd5);
    wait_idle();
  endtask

  // Exit above enter: a reading between them turns the alarm on at one
  // sample and off again at the next.
  task automatic test_crossed_thresholds();
    write_settings(8'sd0, 8'sd10, 16'd2, 16'd1, 16'd1, 16'd1);
    repeat (6) send_reading(8'sd5);
    wait_idle();
  endtask

  // Writes past the last register must leave every setting alone.
  task automatic test_unmapped_writes();
    write_apb(ADDR_UNMAPPED_LO, $urandom());
    write_apb(ADDR_UNMAPPED_HI, $urandom());
    send_reading(8'sd10);
    send_reading(8'sd3);
    send_reading(8'sd12);
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while beats keep coming, so the
  // unit fills both of its registers and has to drop its input ready.
  task automatic test_back_pressure();
    write_settings(8'sd20, 8'sd10, 16'd3, 16'd2, 16'd2, 16'd3);
    tx_gaps_on    = 1'b0;
    long_hold_req = 1'b1;
    repeat (PRESSURE_ITEMS) send_reading(pick_reading());
    wait_idle();
    tx_gaps_on = 1'b1;
  endtask

  // Full-width periods: the alarm is raised with one-tick sampling, then the
  // sample period is widened too, so over the following stretch no sample,
  // blink or beep fires while the counters keep climbing.
  task automatic test_long_idle();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    write_settings(8'sd0, -8'sd128, 16'd1, PERIOD_MAX, PERIOD_MAX, PERIOD_MAX);
    send_reading(8'sd50);
    wait_idle();
    write_apb(reg_addr(hta_pkg::REG_SAMPLE_PERIOD),
              {{(hta_pkg::DATA_W-hta_pkg::CNT_W){1'b0}}, PERIOD_MAX});
    repeat (LONG_IDLE_TICKS) send_reading(near_temp(0, 127));
    wait_idle();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // Phases of random readings, each under fresh settings. The first two
  // phases pin the thresholds to opposite extremes; idling on either side is
  // switched off in some phases to give unbroken stretches.
  task automatic test_random_sequences();
    logic signed [hta_pkg::TEMP_W-1:0] enter_t;
    logic signed [hta_pkg::TEMP_W-1:0] exit_t;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      tx_gaps_on   = (phase % 3 != 2);
      rx_stalls_on = (phase % 4 != 1);
      case (phase)
        0: begin
          enter_t = 8'sd127;
          exit_t  = -8'sd128;
        end
        1: begin
          enter_t = -8'sd128;
          exit_t  = 8'sd127;
        end
        default: begin
          enter_t = any_temp();
          if ($urandom_range(0, 4) == 0) exit_t = any_temp();
          else exit_t = near_temp(int'(enter_t) - 5, 5);
        end
      endcase
      write_settings(enter_t, exit_t, pick_period(), pick_period(), pick_period(),
                     pick_period());
      repeat (RANDOM_PHASE_ITEMS) send_reading(pick_reading());
      wait_idle();
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // Result sink. Random stalls of mixed length when enabled; a requested long
  // hold is counted down here, independent of the sender.
  always @(posedge clk) begin
    if (rst) begin
      alarm_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      stall_left = LONG_HOLD_CYCLES;
      alarm_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      alarm_ch.ready <= 1'b0;
    end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      alarm_ch.ready <= (stall_left == 0);
    end else begin
      alarm_ch.ready <= 1'b1;
    end
  end

  task automatic check_field(input string name,
                             input logic signed [hta_pkg::TEMP_W-1:0] want,
                             input logic signed [hta_pkg::TEMP_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Every accepted tick adds one expectation; every accepted result beat is
  // compared field by field against the oldest one.
  always @(posedge clk) begin
    alarm_beat_t want;
    if (!rst) begin
      if (temp_ch.valid && temp_ch.ready)
        expected_alarm_q.push_back(predict_alarm_tick(temp_ch.temperature_now));
      if (alarm_ch.valid && alarm_ch.ready) begin
        if (expected_alarm_q.size() == 0) begin
          $error("result beat arrived with nothing outstanding");
          fail_count++;
        end else begin
          want = expected_alarm_q.pop_front();
          check_field("alarm_on", {7'd0, want.alarm}, {7'd0, alarm_ch.alarm_on});
          check_field("lamp_on", {7'd0, want.lamp}, {7'd0, alarm_ch.lamp_on});
          check_field("beeper_on", {7'd0, want.beeper}, {7'd0, alarm_ch.beeper_on});
          check_field("sample_taken", {7'd0, want.taken}, {7'd0, alarm_ch.sample_taken});
          check_field("sampled_temp", want.temp, alarm_ch.sampled_temp);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst                     <= 1'b1;
    temp_ch.valid           <= 1'b0;
    temp_ch.temperature_now <= '0;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    fail_count    = 0;
    tx_gaps_on    = 1'b1;
    rx_stalls_on  = 1'b1;
    long_hold_req = 1'b0;

    // The predictor starts from the same state the unit resets to.
    cfg_enter_temp    = hta_pkg::ENTER_TEMP_RST;
    cfg_exit_temp     = hta_pkg::EXIT_TEMP_RST;
    cfg_sample_period = hta_pkg::SAMPLE_PERIOD_RST;
    cfg_blink_period  = hta_pkg::BLINK_PERIOD_RST;
    cfg_beep_off_time = hta_pkg::BEEP_OFF_TIME_RST;
    cfg_beep_on_time  = hta_pkg::BEEP_ON_TIME_RST;
    elapsed_sample    = '0;
    elapsed_blink     = '0;
    elapsed_beep      = '0;
    alarm_state       = 1'b0;
    lamp_state        = 1'b0;
    beep_state        = 1'b0;
    latched_temp      = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_settings();
    test_threshold_extremes();
    test_zero_periods();
    test_crossed_thresholds();
    test_unmapped_writes();
    test_back_pressure();
    test_random_sequences();
    test_long_idle();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
